// File: sv/lwf_pkg.sv
package lwf_pkg;

	// Request command codes.
	localparam logic [1:0] CMD_LIDAR = 2'd0;
	localparam logic [1:0] CMD_ODOM  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Controller modes.
	localparam logic [1:0] MODE_TURN  = 2'd0;
	localparam logic [1:0] MODE_DRIVE = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	// Result kinds.
	localparam logic RES_MOTOR  = 1'b0;
	localparam logic RES_MARKER = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_TOL     = 3'd7;

	// Angles in radians times 4096.
	localparam logic signed [17:0] HALF_PI_Q12       = 18'sd6434;
	localparam logic signed [17:0] THREE_HALF_PI_Q12 = 18'sd19302;
	localparam int TURN_TOLERANCE = 328;
	localparam logic signed [17:0] TURN_LIMIT = HALF_PI_Q12 - 18'(TURN_TOLERANCE);

	// An empty window reads as the farthest range.
	localparam logic [15:0] RANGE_EMPTY = 16'hFFFF;

	// Input request payload.
	typedef struct packed {
		logic [1:0]          command;
		logic [15:0]         range_mm;
		logic signed [15:0]  sample_angle;
		logic                last_sample;
		logic signed [15:0]  odom_x;
		logic signed [15:0]  odom_y;
		logic signed [15:0]  odom_theta;
	} in_req_t;

	// Result payload.
	typedef struct packed {
		logic                result_kind;
		logic [15:0]         speed_out;
		logic signed [15:0]  spin_out;
		logic signed [15:0]  marker_x;
		logic signed [15:0]  marker_y;
		logic [1:0]          mode_out;
	} out_rsp_t;

	// Configuration register set.
	typedef struct packed {
		logic [15:0] drive_speed;
		logic [14:0] turn_rate;
		logic [15:0] heading_gain;
		logic [15:0] distance_gain;
		logic [12:0] window_half_width;
		logic [15:0] min_valid_range;
		logic [15:0] stop_distance;
		logic [15:0] corner_tolerance;
	} cfg_t;

	// Classified request as it waits in the queue.
	typedef struct packed {
		logic [1:0]          kind;
		logic                side_hit;
		logic                front_hit;
		logic                last_sample;
		logic [15:0]         range_mm;
		logic signed [15:0]  sample_angle;
		logic signed [15:0]  odom_x;
		logic signed [15:0]  odom_y;
		logic signed [15:0]  odom_theta;
	} item_t;

endpackage

// File: sv/lidar_wall_follow_controller.sv
// Wall-following controller. One request is taken per clock: lidar samples, odometry updates and
// command ticks. A front stage checks each lidar sample against the side and front windows and
// queues it; the back end applies requests to the controller state at one per clock while the
// output pipeline has room, and that state update sets the rate. A command tick returns a motor
// command and a scan end that starts a corner turn returns a marker; the request passes through
// the queue, the state update register, the gain multiply, then sum and saturate into the output
// register. The input stalls only while the queue is full. Configuration is written through
// cfg_we, cfg_index and cfg_data while the block is idle; the user, not the block, ensures this.
module lidar_wall_follow_controller #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  lwf_pkg::in_req_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output lwf_pkg::out_rsp_t                    out_data,
	input  logic                                 cfg_we,
	input  logic [lwf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lwf_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import lwf_pkg::*;

	cfg_t   cfg_q;
	logic   q_full;
	logic   push;
	item_t  push_item;
	logic   pop;
	logic   head_valid;
	item_t  head_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_speed       <= 16'd500;
			cfg_q.turn_rate         <= 15'd6434;
			cfg_q.heading_gain      <= 16'd5793;
			cfg_q.distance_gain     <= 16'd1049;
			cfg_q.window_half_width <= 13'd2048;
			cfg_q.min_valid_range   <= 16'd100;
			cfg_q.stop_distance     <= 16'd100;
			cfg_q.corner_tolerance  <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DRIVE_SPEED:   cfg_q.drive_speed       <= cfg_data;
				CFG_TURN_RATE:     cfg_q.turn_rate         <= cfg_data[14:0];
				CFG_HEADING_GAIN:  cfg_q.heading_gain      <= cfg_data;
				CFG_DISTANCE_GAIN: cfg_q.distance_gain     <= cfg_data;
				CFG_WINDOW_HALF:   cfg_q.window_half_width <= cfg_data[12:0];
				CFG_MIN_VALID:     cfg_q.min_valid_range   <= cfg_data;
				CFG_STOP_DISTANCE: cfg_q.stop_distance     <= cfg_data;
				CFG_CORNER_TOL:    cfg_q.corner_tolerance  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lwf_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	lwf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	lwf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// File: sv/lwf_front.sv
module lwf_front (
	input  logic             in_valid,
	output logic             in_stall,
	input  lwf_pkg::in_req_t in_data,
	input  lwf_pkg::cfg_t    cfg,
	input  logic             q_full,
	output logic             push,
	output lwf_pkg::item_t   push_item
);
	import lwf_pkg::*;

	logic signed [17:0] ang;
	logic signed [17:0] hw;
	logic signed [17:0] side_lo;
	logic signed [17:0] side_hi;
	logic               range_ok;
	logic               known_cmd;

	// The input side stalls only when the queue has no room.
	assign in_stall = q_full;

	// Unknown commands are accepted and dropped here.
	assign known_cmd = (in_data.command == CMD_LIDAR) || (in_data.command == CMD_ODOM) ||
		(in_data.command == CMD_TICK);
	assign push = in_valid && !q_full && known_cmd;

	// Window test: open intervals around the side and front directions.
	assign ang      = 18'(in_data.sample_angle);
	assign hw       = {5'd0, cfg.window_half_width};
	assign side_lo  = HALF_PI_Q12 - hw;
	assign side_hi  = HALF_PI_Q12 + hw;
	assign range_ok = in_data.range_mm > cfg.min_valid_range;

	always_comb begin
		push_item.kind         = in_data.command;
		push_item.side_hit     = range_ok && (ang > side_lo) && (ang < side_hi);
		push_item.front_hit    = range_ok && (ang > -hw) && (ang < hw);
		push_item.last_sample  = in_data.last_sample;
		push_item.range_mm     = in_data.range_mm;
		push_item.sample_angle = in_data.sample_angle;
		push_item.odom_x       = in_data.odom_x;
		push_item.odom_y       = in_data.odom_y;
		push_item.odom_theta   = in_data.odom_theta;
	end

endmodule

// File: sv/lwf_queue.sv
module lwf_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lwf_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output lwf_pkg::item_t head_item
);
	import lwf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/lwf_back.sv
module lwf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lwf_pkg::cfg_t      cfg,
	input  logic               head_valid,
	input  lwf_pkg::item_t     head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output lwf_pkg::out_rsp_t  out_data
);
	import lwf_pkg::*;

	// Result descriptor as it leaves the state update.
	typedef struct packed {
		logic                kind;
		logic [1:0]          mode;
		logic [15:0]         speed;
		logic signed [15:0]  spin;
		logic                steer;
		logic signed [16:0]  head_err;
		logic signed [16:0]  dist_err;
		logic signed [15:0]  mx;
		logic signed [15:0]  my;
	} desc_t;

	// Descriptor after the gain products.
	typedef struct packed {
		logic                kind;
		logic [1:0]          mode;
		logic [15:0]         speed;
		logic signed [15:0]  spin;
		logic                steer;
		logic signed [33:0]  prod_h;
		logic signed [33:0]  prod_d;
		logic signed [15:0]  mx;
		logic signed [15:0]  my;
	} prod_t;

	// Controller state.
	logic [1:0]         mode_q;
	logic [15:0]        side_min_q;
	logic signed [15:0] side_ang_q;
	logic [15:0]        front_min_q;
	logic [15:0]        target_q;
	logic               target_set_q;
	logic signed [15:0] wall_ang_q;
	logic [15:0]        wall_dist_q;
	logic signed [15:0] turn_head_q;
	logic signed [15:0] last_x_q;
	logic signed [15:0] last_y_q;
	logic signed [15:0] last_head_q;

	logic [1:0]         mode_d;
	logic [15:0]        side_min_d;
	logic signed [15:0] side_ang_d;
	logic [15:0]        front_min_d;
	logic [15:0]        target_d;
	logic               target_set_d;
	logic signed [15:0] wall_ang_d;
	logic [15:0]        wall_dist_d;
	logic signed [15:0] turn_head_d;
	logic signed [15:0] last_x_d;
	logic signed [15:0] last_y_d;
	logic signed [15:0] last_head_d;

	// Pipeline.
	logic     valid_s1;
	desc_t    desc_s1;
	logic     valid_s2;
	prod_t    prod_s2;
	logic     out_valid_q;
	out_rsp_t rsp_q;

	logic     res_valid;
	desc_t    desc_d;
	logic     out_ready;
	logic     s2_ready;
	logic     s1_ready;

	// Scan minima including the current sample.
	logic               side_upd;
	logic               front_upd;
	logic [15:0]        smin;
	logic signed [15:0] sang;
	logic [15:0]        fmin;
	logic [15:0]        diff;
	logic               stop_hit;

	// Turn end test.
	logic signed [17:0] dh;
	logic signed [17:0] adh;
	logic               turn_done;

	// Steering sum, rounding and saturation.
	logic signed [37:0] acc;
	logic signed [37:0] rnd;
	logic signed [37:0] quo;
	logic signed [15:0] steer_spin;

	// Handshake: each stage moves when the one after it has room.
	assign out_ready = !out_valid_q || !out_stall;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign pop       = head_valid && s1_ready;

	assign side_upd  = head_item.side_hit && (head_item.range_mm < side_min_q);
	assign front_upd = head_item.front_hit && (head_item.range_mm < front_min_q);
	assign smin      = side_upd ? head_item.range_mm : side_min_q;
	assign sang      = side_upd ? head_item.sample_angle : side_ang_q;
	assign fmin      = front_upd ? head_item.range_mm : front_min_q;
	assign diff      = (smin > fmin) ? smin - fmin : fmin - smin;
	assign stop_hit  = (fmin < cfg.stop_distance) || (smin < cfg.stop_distance);

	assign dh        = 18'(head_item.odom_theta) - 18'(turn_head_q);
	assign adh       = (dh < 0) ? -dh : dh;
	assign turn_done = ((dh > TURN_LIMIT) || (dh < -TURN_LIMIT)) && (adh < THREE_HALF_PI_Q12);

	// State update for the request at the head of the queue.
	always_comb begin
		mode_d       = mode_q;
		side_min_d   = side_min_q;
		side_ang_d   = side_ang_q;
		front_min_d  = front_min_q;
		target_d     = target_q;
		target_set_d = target_set_q;
		wall_ang_d   = wall_ang_q;
		wall_dist_d  = wall_dist_q;
		turn_head_d  = turn_head_q;
		last_x_d     = last_x_q;
		last_y_d     = last_y_q;
		last_head_d  = last_head_q;
		res_valid    = 1'b0;
		desc_d       = '0;
		if (pop) begin
			case (head_item.kind)
				CMD_LIDAR: begin
					if (!head_item.last_sample) begin
						side_min_d  = smin;
						side_ang_d  = sang;
						front_min_d = fmin;
					end else begin
						// End of scan: latch the wall, then rearm the windows.
						if (!target_set_q) begin
							target_d     = smin;
							target_set_d = 1'b1;
						end
						wall_ang_d  = sang;
						wall_dist_d = smin;
						if (stop_hit) begin
							mode_d = MODE_STOP;
						end else if ((mode_q == MODE_DRIVE) && (diff < cfg.corner_tolerance)) begin
							mode_d      = MODE_TURN;
							turn_head_d = last_head_q;
							res_valid   = 1'b1;
							desc_d.kind = RES_MARKER;
							desc_d.mode = MODE_TURN;
							desc_d.mx   = last_x_q;
							desc_d.my   = last_y_q;
						end
						side_min_d  = RANGE_EMPTY;
						side_ang_d  = '0;
						front_min_d = RANGE_EMPTY;
					end
				end
				CMD_ODOM: begin
					last_x_d    = head_item.odom_x;
					last_y_d    = head_item.odom_y;
					last_head_d = head_item.odom_theta;
					if ((mode_q == MODE_TURN) && turn_done) begin
						mode_d = MODE_DRIVE;
					end
				end
				CMD_TICK: begin
					res_valid   = 1'b1;
					desc_d.kind = RES_MOTOR;
					desc_d.mode = mode_q;
					case (mode_q)
						MODE_TURN: begin
							desc_d.spin = {1'b0, cfg.turn_rate};
						end
						MODE_DRIVE: begin
							desc_d.speed    = cfg.drive_speed;
							desc_d.steer    = 1'b1;
							desc_d.head_err = 17'(HALF_PI_Q12 - 18'(wall_ang_q));
							if (target_set_q) begin
								desc_d.dist_err = $signed({1'b0, target_q}) -
									$signed({1'b0, wall_dist_q});
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_DRIVE;
			side_min_q   <= RANGE_EMPTY;
			side_ang_q   <= '0;
			front_min_q  <= RANGE_EMPTY;
			target_q     <= '0;
			target_set_q <= 1'b0;
			wall_ang_q   <= '0;
			wall_dist_q  <= '0;
			turn_head_q  <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_head_q  <= '0;
		end else begin
			mode_q       <= mode_d;
			side_min_q   <= side_min_d;
			side_ang_q   <= side_ang_d;
			front_min_q  <= front_min_d;
			target_q     <= target_d;
			target_set_q <= target_set_d;
			wall_ang_q   <= wall_ang_d;
			wall_dist_q  <= wall_dist_d;
			turn_head_q  <= turn_head_d;
			last_x_q     <= last_x_d;
			last_y_q     <= last_y_d;
			last_head_q  <= last_head_d;
		end
	end

	// Steering law: sum of products, round half up, saturate to 16 bits.
	assign acc = 38'(prod_s2.prod_h) + (38'(prod_s2.prod_d) <<< 4);
	assign rnd = acc + 38'sd2048;
	assign quo = rnd >>> 12;

	always_comb begin
		if (quo > 38'sd32767) begin
			steer_spin = 16'sh7FFF;
		end else if (quo < -38'sd32768) begin
			steer_spin = 16'sh8000;
		end else begin
			steer_spin = quo[15:0];
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= res_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Pipeline payload: gain products, then the result register.
	always_ff @(posedge clk) begin
		if (s1_ready) begin
			desc_s1 <= desc_d;
		end
		if (s2_ready) begin
			prod_s2.kind   <= desc_s1.kind;
			prod_s2.mode   <= desc_s1.mode;
			prod_s2.speed  <= desc_s1.speed;
			prod_s2.spin   <= desc_s1.spin;
			prod_s2.steer  <= desc_s1.steer;
			prod_s2.prod_h <= $signed({1'b0, cfg.heading_gain}) * desc_s1.head_err;
			prod_s2.prod_d <= $signed({1'b0, cfg.distance_gain}) * desc_s1.dist_err;
			prod_s2.mx     <= desc_s1.mx;
			prod_s2.my     <= desc_s1.my;
		end
		if (out_ready) begin
			rsp_q.result_kind <= prod_s2.kind;
			rsp_q.speed_out   <= prod_s2.speed;
			rsp_q.spin_out    <= prod_s2.steer ? steer_spin : prod_s2.spin;
			rsp_q.marker_x    <= prod_s2.mx;
			rsp_q.marker_y    <= prod_s2.my;
			rsp_q.mode_out    <= prod_s2.mode;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

endmodule
